@@ rtl/text_console_writer_assert.svh @@
// Assertion macros for the text console writer.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; used by tcw_ctrl, tcw_datapath and the top level, but not by tcw_ram.
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] KIND_PRINT = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PLACE = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  RESET_ATTR   = 8'h07;
  localparam logic [15:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};
  localparam int          CURSOR_IDX_W = 11;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [6:0] column_select;
    logic [4:0] row_select;
    logic [7:0] cell_attr;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0]             read_cell;
    logic [CURSOR_IDX_W-1:0] cursor_index;
    logic                    scrolled;
  } tcw_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL
  } tcw_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic scroll_step;
    logic cnt_clr;
    logic print_wr;
    logic place_wr;
    logic cell_rd;
    logic cur_next_row;
    logic cur_advance;
    logic finish;
    logic finish_scroll;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic newline;
    logic col_last;
    logic row_last;
    logic in_range;
    logic clear_end;
    logic scroll_end;
  } tcw_stat_t;

endpackage

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// Controller state machine of the text console writer: clearing pass, idle, scroll.
// Depends on tcw_pkg for the state, command and status types.
`default_nettype none

module tcw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire [1:0]           kind_i,
  input  tcw_pkg::tcw_stat_t  stat_i,
  output tcw_pkg::tcw_cmd_t   cmd_o,
  output logic                busy_o
);

  import tcw_pkg::*;

  tcw_state_e state_q, state_d;
  logic       wraps_row;

  // A print leaves the current row on a newline or on the last column.
  assign wraps_row = stat_i.newline || stat_i.col_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i && kind_i == KIND_PRINT && wraps_row && stat_i.row_last) begin
          state_d = ST_SCROLL;
        end
      end
      ST_SCROLL: begin
        if (stat_i.scroll_end) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            KIND_PRINT: begin
              cmd_o.print_wr = !stat_i.newline;
              if (wraps_row) begin
                cmd_o.cur_next_row = 1'b1;
                cmd_o.cnt_clr      = stat_i.row_last;
                cmd_o.finish       = !stat_i.row_last;
              end else begin
                cmd_o.cur_advance = 1'b1;
                cmd_o.finish      = 1'b1;
              end
            end
            KIND_READ: begin
              cmd_o.cell_rd = stat_i.in_range;
              cmd_o.finish  = 1'b1;
            end
            KIND_PLACE: begin
              cmd_o.place_wr = stat_i.in_range;
              cmd_o.finish   = 1'b1;
            end
            default: begin
              cmd_o.finish = 1'b1;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll_step   = 1'b1;
        cmd_o.finish_scroll = stat_i.scroll_end;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
// Datapath of the text console writer: screen RAM, cursor, attribute, sweep counter.
// Depends on tcw_pkg and tcw_ram.
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  tcw_pkg::tcw_cmd_t  cmd_i,
  output tcw_pkg::tcw_stat_t stat_o,
  input  tcw_pkg::tcw_in_t   in_i,
  input  wire                cfg_we_i,
  input  wire [7:0]          cfg_data_i,
  output logic               done_o,
  output tcw_pkg::tcw_out_t  result_o
);

  import tcw_pkg::*;

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COPY_CNT = COLUMNS * (ROWS - 1);
  localparam int AW       = $clog2(CELLS);
  localparam int CNTW     = $clog2(CELLS + 1);
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int IW       = (AW > CURSOR_IDX_W) ? AW : CURSOR_IDX_W;

  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic [7:0]      attr_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;
  logic            scrolled_q;
  logic            read_sel_q;

  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   sel_addr;
  logic            copy_rd;
  logic            fill;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [15:0]     wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [15:0]     rdata;
  logic [IW-1:0]   cursor_full;

  assign stat_o.newline    = (in_i.char_code == NEWLINE_CODE);
  assign stat_o.col_last   = (col_q == CW'(COLUMNS - 1));
  assign stat_o.row_last   = (row_q == RW'(ROWS - 1));
  assign stat_o.in_range   = (int'(in_i.column_select) < COLUMNS) &&
                             (int'(in_i.row_select) < ROWS);
  assign stat_o.clear_end  = (cnt_q == CNTW'(CELLS - 1));
  assign stat_o.scroll_end = (cnt_q == CNTW'(CELLS));

  assign cur_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign sel_addr = AW'(in_i.row_select) * AW'(COLUMNS) + AW'(in_i.column_select);

  // During a scroll the counter reads one row ahead and writes the word read
  // in the previous cycle one row up; past the copied area it fills blanks.
  assign copy_rd = (cnt_q < CNTW'(COPY_CNT));
  assign fill    = (cnt_q > CNTW'(COPY_CNT));

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {attr_q, in_i.char_code};
    if (cmd_i.clear_wr) begin
      we    = 1'b1;
      waddr = AW'(cnt_q);
      wdata = RESET_CELL;
    end else if (cmd_i.scroll_step) begin
      we    = (cnt_q != '0);
      waddr = AW'(cnt_q - CNTW'(1));
      wdata = fill ? {attr_q, SPACE_CODE} : rdata;
    end else if (cmd_i.place_wr) begin
      we    = 1'b1;
      waddr = sel_addr;
      wdata = {in_i.cell_attr, in_i.char_code};
    end else if (cmd_i.print_wr) begin
      we    = 1'b1;
    end
  end

  assign re    = cmd_i.cell_rd || (cmd_i.scroll_step && copy_rd);
  assign raddr = cmd_i.scroll_step ? AW'(cnt_q + CNTW'(COLUMNS)) : sel_addr;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      attr_q     <= RESET_ATTR;
      cnt_q      <= '0;
      done_q     <= 1'b0;
      scrolled_q <= 1'b0;
      read_sel_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
      if (cmd_i.cur_next_row) begin
        col_q <= '0;
        if (!stat_o.row_last) begin
          row_q <= row_q + RW'(1);
        end
      end else if (cmd_i.cur_advance) begin
        col_q <= col_q + CW'(1);
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.clear_wr || cmd_i.scroll_step) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
      done_q     <= cmd_i.finish || cmd_i.finish_scroll;
      scrolled_q <= cmd_i.finish_scroll;
      read_sel_q <= cmd_i.cell_rd;
    end
  end

  // The cursor registers already hold the post-step position in the result cycle.
  assign cursor_full = IW'(row_q) * IW'(COLUMNS) + IW'(col_q);

  assign done_o                = done_q;
  assign result_o.read_cell    = read_sel_q ? rdata : 16'h0000;
  assign result_o.cursor_index = cursor_full[CURSOR_IDX_W-1:0];
  assign result_o.scrolled     = scrolled_q;

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// Text console writer top level: controller plus datapath around a screen RAM.
// Print, read, place and no-op words give their result in the cycle after start; a word
// that scrolls copies the screen with busy high and gives its result after the sweep.
// After reset a clearing pass writes every cell with busy high; the attribute resets
// to 7 and the cursor to the top left. Results cannot be stalled.
`default_nettype none
`include "text_console_writer_assert.svh"

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  tcw_pkg::tcw_in_t   in_i,
  output logic               done_o,
  output tcw_pkg::tcw_out_t  result_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire [7:0]          cfg_data_i
);

  import tcw_pkg::*;

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  // The attribute register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (in_i.kind),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_i       (in_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  `TCW_ASSERT_NEXT(a_place_done, start && !busy && in_i.kind == KIND_PLACE, done_o, "place word gave no result")
  `TCW_ASSERT_NOW(a_scroll_after_busy, done_o && result_o.scrolled, $past(busy), "scroll result without a sweep")
  `TCW_ASSERT_NOW(a_cell_only_on_read, done_o && result_o.read_cell != 16'h0000, $past(start && !busy && in_i.kind == KIND_READ), "cell data on a non-read result")

endmodule

`default_nettype wire

@@ test/text_console_writer_test.sv @@
// Self-checking testbench for text_console_writer: directed cases, then random print, read,
// place and no-op traffic, checked against a cycle-free mirror of the screen and cursor.
// Depends on tcw_pkg and the text_console_writer RTL only.
`timescale 1ns / 100ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_TOTAL  = SCREEN_COLS * SCREEN_ROWS;
  localparam logic [1:0] KIND_NOP = 2'd3;
  // Each scroll sweeps the whole screen, so the random part stops causing scrolls at this cap.
  localparam int SCROLL_CAP = 120;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  tcw_in_t    in_i;
  logic       done_o;
  tcw_out_t   result_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;

  logic [15:0] screen_mirror [0:CELL_TOTAL-1];
  int          cursor_col;
  int          cursor_row;
  logic [7:0]  print_attr;
  int          scroll_total;
  tcw_out_t    pending_results [$];
  int          fail_count;

  text_console_writer #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Moves the mirrored cursor to the start of the next row, scrolling on the last row.
  function automatic logic next_row();
    cursor_col = 0;
    if (cursor_row >= SCREEN_ROWS - 1) begin
      cursor_row = SCREEN_ROWS - 1;
      for (int i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++)
        screen_mirror[i] = screen_mirror[i + SCREEN_COLS];
      for (int x = 0; x < SCREEN_COLS; x++)
        screen_mirror[(SCREEN_ROWS - 1) * SCREEN_COLS + x] = {print_attr, SPACE_CODE};
      scroll_total++;
      return 1'b1;
    end
    cursor_row++;
    return 1'b0;
  endfunction

  function automatic tcw_out_t console_step(input tcw_in_t w);
    tcw_out_t r;
    int       col;
    int       row;
    logic     in_range;
    r = '0;
    col = w.column_select;
    row = w.row_select;
    in_range = (col < SCREEN_COLS) && (row < SCREEN_ROWS);
    case (w.kind)
      KIND_PRINT: begin
        if (w.char_code == NEWLINE_CODE) begin
          r.scrolled = next_row();
        end else begin
          screen_mirror[cursor_row * SCREEN_COLS + cursor_col] = {print_attr, w.char_code};
          cursor_col++;
          if (cursor_col >= SCREEN_COLS) r.scrolled = next_row();
        end
      end
      KIND_READ: begin
        if (in_range) r.read_cell = screen_mirror[row * SCREEN_COLS + col];
      end
      KIND_PLACE: begin
        if (in_range) screen_mirror[row * SCREEN_COLS + col] = {w.cell_attr, w.char_code};
      end
      default: ;
    endcase
    r.cursor_index = CURSOR_IDX_W'(cursor_row * SCREEN_COLS + cursor_col);
    return r;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows
  // acceptance, with start still high so that the next word can follow back to back.
  task automatic send_word(input tcw_in_t w);
    logic taken;
    in_i = w;
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1'b1;
        pending_results.push_back(console_step(w));
      end
    end
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    do @(posedge clk_i); while (busy || pending_results.size() != 0);
    @(negedge clk_i);
  endtask

  task automatic write_attr(input logic [7:0] value);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    print_attr = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic tcw_in_t make_word(input logic [1:0] kind, input logic [7:0] ch,
                                        input int col, input int row,
                                        input logic [7:0] attr);
    tcw_in_t w;
    w.kind = kind;
    w.char_code = ch;
    w.column_select = 7'(col);
    w.row_select = 5'(row);
    w.cell_attr = attr;
    return w;
  endfunction

  function automatic tcw_in_t random_word();
    tcw_in_t w;
    int      pick;
    int      aim;
    w.char_code = 8'($urandom_range(0, 255));
    w.cell_attr = 8'($urandom_range(0, 255));
    w.column_select = 7'($urandom_range(0, SCREEN_COLS - 1));
    w.row_select = 5'($urandom_range(0, SCREEN_ROWS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      w.kind = KIND_PRINT;
      if ($urandom_range(0, 7) == 0) w.char_code = NEWLINE_CODE;
    end else if (pick < 80) begin
      w.kind = KIND_READ;
      aim = $urandom_range(0, 9);
      if (aim == 0) begin
        w.column_select = 7'($urandom_range(0, 127));
        w.row_select = 5'($urandom_range(0, 31));
      end else if (aim < 6) begin
        // Look at the cell most recently printed.
        w.column_select = 7'((cursor_col > 0) ? cursor_col - 1 : 0);
        w.row_select = 5'(cursor_row);
      end
    end else if (pick < 95) begin
      w.kind = KIND_PLACE;
      if ($urandom_range(0, 9) == 0) begin
        w.column_select = 7'($urandom_range(0, 127));
        w.row_select = 5'($urandom_range(0, 31));
      end
    end else begin
      w.kind = KIND_NOP;
      w.column_select = 7'($urandom_range(0, 127));
      w.row_select = 5'($urandom_range(0, 31));
    end
    if (scroll_total >= SCROLL_CAP && w.kind == KIND_PRINT && cursor_row == SCREEN_ROWS - 1 &&
        (w.char_code == NEWLINE_CODE || cursor_col == SCREEN_COLS - 1))
      w.kind = KIND_READ;
    return w;
  endfunction

  task automatic test_reset_screen();
    send_word(make_word(KIND_READ, 8'h00, 0, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'hFF, SCREEN_COLS - 1, SCREEN_ROWS - 1, 8'hFF));
    send_word(make_word(KIND_READ, 8'h00, 40, 12, 8'h00));
    send_word(make_word(KIND_NOP, 8'hFF, 127, 31, 8'hFF));
  endtask

  task automatic test_place_and_read();
    send_word(make_word(KIND_PLACE, 8'hFF, SCREEN_COLS - 1, SCREEN_ROWS - 1, 8'hFF));
    send_word(make_word(KIND_READ, 8'h00, SCREEN_COLS - 1, SCREEN_ROWS - 1, 8'h00));
    send_word(make_word(KIND_PLACE, 8'h00, 0, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 0, 0, 8'h00));
    // A newline placed directly is stored as a plain byte.
    send_word(make_word(KIND_PLACE, NEWLINE_CODE, 5, 3, 8'h1E));
    send_word(make_word(KIND_READ, 8'h00, 5, 3, 8'h00));
  endtask

  task automatic test_out_of_range();
    send_word(make_word(KIND_PLACE, 8'h41, 127, 31, 8'h4E));
    send_word(make_word(KIND_PLACE, 8'h42, SCREEN_COLS, 0, 8'h4E));
    send_word(make_word(KIND_PLACE, 8'h43, 0, SCREEN_ROWS, 8'h4E));
    send_word(make_word(KIND_READ, 8'h00, SCREEN_COLS, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 0, SCREEN_ROWS, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 127, 31, 8'h00));
  endtask

  task automatic test_print();
    send_word(make_word(KIND_PRINT, 8'h41, 0, 0, 8'h00));
    send_word(make_word(KIND_PRINT, 8'h00, 127, 31, 8'hFF));
    send_word(make_word(KIND_PRINT, 8'hFF, 0, 0, 8'h00));
    send_word(make_word(KIND_PRINT, NEWLINE_CODE, 0, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 0, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 1, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 2, 0, 8'h00));
    pause_sender(1);
  endtask

  task automatic test_scroll();
    logic [7:0] ch;
    while (cursor_row != SCREEN_ROWS - 1)
      send_word(make_word(KIND_PRINT, NEWLINE_CODE, 0, 0, 8'h00));
    send_word(make_word(KIND_PLACE, 8'h5A, 3, SCREEN_ROWS - 1, 8'hC3));
    send_word(make_word(KIND_PRINT, NEWLINE_CODE, 0, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 3, SCREEN_ROWS - 2, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, 3, SCREEN_ROWS - 1, 8'h00));
    // Fill the last row so that the wrap itself scrolls.
    while (cursor_col != SCREEN_COLS - 1) begin
      ch = 8'($urandom_range(0, 255));
      if (ch == NEWLINE_CODE) ch = 8'h2A;
      send_word(make_word(KIND_PRINT, ch, 0, 0, 8'h00));
    end
    send_word(make_word(KIND_PRINT, 8'h7E, 0, 0, 8'h00));
    send_word(make_word(KIND_READ, 8'h00, SCREEN_COLS - 1, SCREEN_ROWS - 2, 8'h00));
    pause_sender(1);
  endtask

  task automatic test_random_traffic(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && left > 0) begin
        send_word(random_word());
        burst--;
        left--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    pause_sender(1);
  endtask

  always @(posedge clk_i) begin
    tcw_out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, result_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.read_cell !== want.read_cell) begin
          $display("%0t: read_cell expected %h actual %h", $time, want.read_cell,
                   result_o.read_cell);
          fail_count++;
        end
        if (result_o.cursor_index !== want.cursor_index) begin
          $display("%0t: cursor_index expected %0d actual %0d", $time, want.cursor_index,
                   result_o.cursor_index);
          fail_count++;
        end
        if (result_o.scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time, want.scrolled,
                   result_o.scrolled);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [7:0] phase_attr [5];
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    fail_count = 0;
    scroll_total = 0;
    cursor_col = 0;
    cursor_row = 0;
    print_attr = RESET_ATTR;
    for (int i = 0; i < CELL_TOTAL; i++) screen_mirror[i] = RESET_CELL;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_screen();
    test_place_and_read();
    test_out_of_range();
    test_print();
    write_attr(8'h00);
    test_scroll();

    phase_attr[0] = 8'hFF;
    phase_attr[1] = 8'($urandom_range(0, 255));
    phase_attr[2] = 8'h00;
    phase_attr[3] = 8'($urandom_range(0, 255));
    phase_attr[4] = 8'hA5;
    for (int p = 0; p < 5; p++) begin
      write_attr(phase_attr[p]);
      test_random_traffic(280);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
